/* sv/tle_pkg.sv */
package tle_pkg;

    // One character byte as it moves through the editor.
    typedef logic [7:0] t_byte;

    // Control characters that the editor recognizes or echoes.
    localparam t_byte CH_ESC = 8'd27;
    localparam t_byte CH_LF  = 8'd10;
    localparam t_byte CH_BS  = 8'd8;
    localparam t_byte CH_CR  = 8'd13;
    localparam t_byte CH_BEL = 8'd7;
    localparam t_byte CH_SP  = 8'd32;
    localparam t_byte CH_BSL = 8'd92;
    localparam t_byte CH_NUL = 8'd0;

    // Result kind codes.
    localparam logic KIND_ECHO = 1'b0;
    localparam logic KIND_LINE = 1'b1;

endpackage

/* sv/terminal_line_editor.sv */
// Order: an echo result is loaded into the output register from S_ECHO, entered on the byte's transfer;
// a CR goes from S_IDLE to S_RDA, and then S_RDW or S_TERM loads its first result.
// A new byte is taken only in S_IDLE, so all echo and line bytes of a byte are sent first; a line end
// reads each stored character (S_RDA memory read, then S_RDW output load) and then loads the
// terminator (S_TERM). A full output register holds S_ECHO, S_RDW and S_TERM until it drains.
// Reset: synchronous, active low; it empties the line and the output register, not the memory.
module terminal_line_editor #(
    parameter int LINE_BUFFER_SIZE = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  tle_pkg::t_byte i_rx_byte,
    output logic           o_valid,
    input  logic           i_ready,
    output tle_pkg::t_byte o_out_byte,
    output logic           o_out_kind,
    output logic           o_line_end,
    output logic           o_last
);

    import tle_pkg::*;

    localparam int IW = (LINE_BUFFER_SIZE > 1) ? $clog2(LINE_BUFFER_SIZE) : 1;
    localparam logic [IW-1:0] FULL_FILL = IW'(LINE_BUFFER_SIZE - 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ECHO = 3'd1;
    localparam logic [2:0] S_RDA  = 3'd2;
    localparam logic [2:0] S_RDW  = 3'd3;
    localparam logic [2:0] S_TERM = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [IW-1:0] r_fill, n_fill;
    logic [IW-1:0] r_rd_idx, n_rd_idx;
    logic [IW-1:0] r_line_n, n_line_n;
    t_byte         r_echo [3];
    t_byte         n_echo [3];
    logic [1:0]    r_echo_pos, n_echo_pos;
    logic [1:0]    r_echo_len, n_echo_len;
    logic          r_then_line, n_then_line;

    logic          r_valid, n_valid;
    t_byte         r_out_byte, n_out_byte;
    logic          r_out_kind, n_out_kind;
    logic          r_line_end, n_line_end;
    logic          r_last, n_last;

    t_byte         r_mem [LINE_BUFFER_SIZE];
    t_byte         r_rd_data;
    logic          mem_we;
    logic [IW-1:0] fill_inc;
    logic          slot_free;
    logic          in_xfer;

    assign o_ready    = (r_state == S_IDLE);
    assign in_xfer    = i_valid && o_ready;
    assign slot_free  = !r_valid || i_ready;
    assign fill_inc   = r_fill + 1'b1;

    assign o_valid    = r_valid;
    assign o_out_byte = r_out_byte;
    assign o_out_kind = r_out_kind;
    assign o_line_end = r_line_end;
    assign o_last     = r_last;

    // Line memory: written when a plain character is taken, read one entry per line byte.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_fill] <= i_rx_byte;
        end
        r_rd_data <= r_mem[r_rd_idx];
    end

    // Sequencer and output register next-state logic.
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_rd_idx    = r_rd_idx;
        n_line_n    = r_line_n;
        n_echo      = r_echo;
        n_echo_pos  = r_echo_pos;
        n_echo_len  = r_echo_len;
        n_then_line = r_then_line;
        n_valid     = r_valid && !i_ready;
        n_out_byte  = r_out_byte;
        n_out_kind  = r_out_kind;
        n_line_end  = r_line_end;
        n_last      = r_last;
        mem_we      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_echo_pos  = 2'd0;
                    n_then_line = 1'b0;
                    n_rd_idx    = '0;
                    case (i_rx_byte)
                        CH_ESC: begin
                            n_echo[0]  = CH_BSL;
                            n_echo[1]  = CH_CR;
                            n_echo[2]  = CH_LF;
                            n_echo_len = 2'd3;
                            n_fill     = '0;
                            n_state    = S_ECHO;
                        end
                        CH_LF: begin
                            n_state = S_IDLE;
                        end
                        CH_BS: begin
                            if (r_fill != '0) begin
                                n_echo[0]  = CH_BS;
                                n_echo[1]  = CH_SP;
                                n_echo[2]  = CH_BS;
                                n_echo_len = 2'd3;
                                n_fill     = r_fill - 1'b1;
                            end else begin
                                n_echo[0]  = CH_BEL;
                                n_echo_len = 2'd1;
                            end
                            n_state = S_ECHO;
                        end
                        CH_CR: begin
                            n_line_n = r_fill;
                            n_fill   = '0;
                            n_state  = S_RDA;
                        end
                        default: begin
                            // Plain character: store, echo, and end the line at size minus one.
                            mem_we     = 1'b1;
                            n_echo[0]  = i_rx_byte;
                            n_echo_len = 2'd1;
                            if (fill_inc >= FULL_FILL) begin
                                n_then_line = 1'b1;
                                n_line_n    = fill_inc;
                                n_fill      = '0;
                            end else begin
                                n_fill = fill_inc;
                            end
                            n_state = S_ECHO;
                        end
                    endcase
                end
            end
            S_ECHO: begin
                if (slot_free) begin
                    n_valid    = 1'b1;
                    n_out_byte = r_echo[r_echo_pos];
                    n_out_kind = KIND_ECHO;
                    n_line_end = 1'b0;
                    n_last     = 1'b0;
                    if (r_echo_pos == r_echo_len - 2'd1) begin
                        if (r_then_line) begin
                            n_state = S_RDA;
                        end else begin
                            n_last  = 1'b1;
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_echo_pos = r_echo_pos + 2'd1;
                    end
                end
            end
            S_RDA: begin
                // The read address is r_rd_idx; its data is ready in the next state.
                if (r_rd_idx == r_line_n) begin
                    n_state = S_TERM;
                end else begin
                    n_state = S_RDW;
                end
            end
            S_RDW: begin
                if (slot_free) begin
                    n_valid    = 1'b1;
                    n_out_byte = r_rd_data;
                    n_out_kind = KIND_LINE;
                    n_line_end = 1'b0;
                    n_last     = 1'b0;
                    n_rd_idx   = r_rd_idx + 1'b1;
                    n_state    = S_RDA;
                end
            end
            S_TERM: begin
                if (slot_free) begin
                    n_valid    = 1'b1;
                    n_out_byte = CH_NUL;
                    n_out_kind = KIND_LINE;
                    n_line_end = 1'b1;
                    n_last     = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_valid <= n_valid;
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        r_rd_idx    <= n_rd_idx;
        r_line_n    <= n_line_n;
        r_echo      <= n_echo;
        r_echo_pos  <= n_echo_pos;
        r_echo_len  <= n_echo_len;
        r_then_line <= n_then_line;
        r_out_byte  <= n_out_byte;
        r_out_kind  <= n_out_kind;
        r_line_end  <= n_line_end;
        r_last      <= n_last;
    end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    import tle_pkg::*;

    localparam int LINE_MAX     = 32;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 40;

    // One expected or observed result.
    typedef struct {
        t_byte data;
        logic  kind;
        logic  line_end;
        logic  last;
    } t_result;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_ready;
    t_byte i_rx_byte;
    logic  o_valid;
    logic  i_ready;
    t_byte o_out_byte;
    logic  o_out_kind;
    logic  o_line_end;
    logic  o_last;

    // Shadow copy of the line being edited.
    t_byte   line_mem [LINE_MAX];
    int      line_len;
    t_result pending_out [$];

    int  error_count;
    int  bytes_sent;
    int  results_seen;
    int  lines_done;
    int  full_lines;
    bit  tx_idle;
    bit  rx_idle;
    int  hold_asks;

    terminal_line_editor #(
        .LINE_BUFFER_SIZE(LINE_MAX)
    ) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_rx_byte (i_rx_byte),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_out_byte(o_out_byte),
        .o_out_kind(o_out_kind),
        .o_line_end(o_line_end),
        .o_last    (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void push_out(input t_byte data, input logic kind, input logic line_end);
        t_result r;
        r.data     = data;
        r.kind     = kind;
        r.line_end = line_end;
        r.last     = 1'b0;
        pending_out.push_back(r);
    endfunction

    // Emit the stored characters and the terminator, then empty the line.
    function automatic void flush_line();
        for (int i = 0; i < line_len; i++) begin
            push_out(line_mem[i], KIND_LINE, 1'b0);
        end
        push_out(CH_NUL, KIND_LINE, 1'b1);
        line_len = 0;
        lines_done++;
    endfunction

    // Apply one received byte to the shadow line and queue what it produces.
    function automatic void edit_line(input t_byte b);
        int before_size;
        before_size = pending_out.size();
        case (b)
            CH_ESC: begin
                push_out(CH_BSL, KIND_ECHO, 1'b0);
                push_out(CH_CR, KIND_ECHO, 1'b0);
                push_out(CH_LF, KIND_ECHO, 1'b0);
                line_len = 0;
            end
            CH_LF: begin
            end
            CH_BS: begin
                if (line_len > 0) begin
                    line_len--;
                    push_out(CH_BS, KIND_ECHO, 1'b0);
                    push_out(CH_SP, KIND_ECHO, 1'b0);
                    push_out(CH_BS, KIND_ECHO, 1'b0);
                end else begin
                    push_out(CH_BEL, KIND_ECHO, 1'b0);
                end
            end
            CH_CR: begin
                flush_line();
            end
            default: begin
                line_mem[line_len] = b;
                line_len++;
                push_out(b, KIND_ECHO, 1'b0);
                if (line_len >= LINE_MAX - 1) begin
                    full_lines++;
                    flush_line();
                end
            end
        endcase
        if (pending_out.size() > before_size) begin
            pending_out[pending_out.size() - 1].last = 1'b1;
        end
    endfunction

    // A byte that the editor treats as plain text.
    function automatic t_byte text_byte();
        t_byte b;
        do begin
            b = t_byte'($urandom_range(0, 255));
        end while (b == CH_ESC || b == CH_LF || b == CH_BS || b == CH_CR);
        return b;
    endfunction

    // Offer one byte and wait for its transfer; valid stays high into the next byte.
    task automatic send_byte(input t_byte b);
        int gap;
        gap = tx_idle ? $urandom_range(0, 5) : 0;
        @(negedge i_clk);
        repeat (gap) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        forever begin
            @(posedge i_clk);
            if (o_ready) break;
        end
        bytes_sent++;
        edit_line(b);
    endtask

    // Compare the result on the outputs with the oldest expectation.
    task automatic check_out();
        t_result want;
        results_seen++;
        if (pending_out.size() == 0) begin
            $display("%0t: unexpected result, expected none, got byte %02h kind %0d end %0d last %0d",
                     $time, o_out_byte, o_out_kind, o_line_end, o_last);
            error_count++;
        end else begin
            want = pending_out.pop_front();
            if (o_out_byte !== want.data || o_out_kind !== want.kind ||
                o_line_end !== want.line_end || o_last !== want.last) begin
                $display("%0t: mismatch, expected byte %02h kind %0d end %0d last %0d, got byte %02h kind %0d end %0d last %0d",
                         $time, want.data, want.kind, want.line_end, want.last,
                         o_out_byte, o_out_kind, o_line_end, o_last);
                error_count++;
            end
        end
    endtask

    // Output side: checks each transfer, then stalls at random or for a long hold-off.
    initial begin : out_side
        int gap;
        int hold_left;
        int hold_seen;
        gap       = 0;
        hold_left = 0;
        hold_seen = 0;
        i_ready   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                check_out();
                gap = rx_idle ? $urandom_range(0, 5) : 0;
            end
            @(negedge i_clk);
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (gap > 0) begin
                gap--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run when no transfer happens on either side for too long.
    initial begin : watchdog
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                stall = 0;
            end else begin
                stall++;
            end
        end
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // Extremes of the byte, every control character that the editor recognizes, and the empty-line cases.
    task automatic test_directed();
        t_byte seq [] = '{CH_BS, CH_CR, CH_LF, 8'h00, 8'hFF, 8'h41, CH_BS, 8'h7F, CH_LF,
                          CH_CR, CH_ESC, 8'h78, 8'h79, CH_ESC, CH_CR, CH_BEL, CH_SP, 8'h80,
                          8'h01, CH_BS, CH_BS, CH_BS, CH_BS, CH_CR};
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        foreach (seq[i]) begin
            send_byte(seq[i]);
        end
    endtask

    // Fill the store so the line ends on its own, once with a backspace on the way.
    task automatic test_full_line();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        repeat (LINE_MAX - 1) send_byte(text_byte());
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        repeat (10) send_byte(text_byte());
        send_byte(CH_BS);
        while (line_len != 0) send_byte(text_byte());
    endtask

    // Mostly well-formed lines with random text, some noise in between.
    task automatic test_random_lines(input int n_items);
        int start;
        int pick;
        int len;
        start = bytes_sent;
        while (bytes_sent - start < n_items) begin
            pick    = $urandom_range(0, 99);
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            if (pick < 10) begin
                repeat ($urandom_range(1, 8)) send_byte(t_byte'($urandom_range(0, 255)));
            end else if (pick < 18) begin
                while (line_len < LINE_MAX - 2) send_byte(text_byte());
                send_byte(text_byte());
            end else begin
                len = $urandom_range(0, 12);
                repeat (len) begin
                    if ($urandom_range(0, 99) < 12) send_byte(CH_BS);
                    else send_byte(text_byte());
                end
                pick = $urandom_range(0, 99);
                if (pick < 80) send_byte(CH_CR);
                else if (pick < 95) send_byte(CH_ESC);
                else send_byte(CH_LF);
            end
        end
    endtask

    // Hold the output off while a full line and more bytes are offered.
    task automatic test_output_hold();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        hold_asks++;
        while (line_len < LINE_MAX - 2) send_byte(text_byte());
        send_byte(text_byte());
        repeat (12) send_byte(text_byte());
        send_byte(CH_CR);
        rx_idle = 1'b1;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_rx_byte   = '0;
        line_len    = 0;
        error_count = 0;
        bytes_sent  = 0;
        results_seen = 0;
        lines_done  = 0;
        full_lines  = 0;
        tx_idle     = 1'b1;
        rx_idle     = 1'b1;
        hold_asks   = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_full_line();
        test_random_lines(330);
        test_output_hold();

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_out.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes and checked %0d results over %0d lines, %0d ended by a full store.",
                 bytes_sent, results_seen, lines_done, full_lines);
        $display("Input and output idled at random, with one long output hold-off.");
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
